@@ src/gms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_pkg: shared types and constants for the register stub
// Register offsets, fixed read words, bit masks and the bus access struct.
// ----------------------------------------------------------------------------
package gms_pkg;

	localparam int unsigned AddrW = 28;
	localparam int unsigned DataW = 32;

	typedef logic [AddrW-1:0] addr_t;
	typedef logic [DataW-1:0] word_t;

	// one bus access
	typedef struct packed {
		logic  op;     // 1 = write
		addr_t addr;
		word_t wdata;
	} gms_access_t;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// offsets
	localparam addr_t OFS_GT_ID     = 28'h00D8C;
	localparam addr_t OFS_DISP_ID   = 28'h510A0;
	localparam addr_t OFS_WAKE_GSC  = 28'h0A618;
	localparam addr_t OFS_ACK_GSC   = 28'h00DF8;
	localparam addr_t OFS_WAKE_GT   = 28'h0A188;
	localparam addr_t OFS_ACK_GT_A  = 28'h130044;
	localparam addr_t OFS_ACK_GT_B  = 28'h00DFC;
	localparam addr_t OFS_MEM_INFO  = 28'h45700;
	localparam addr_t OFS_STEER     = 28'h00FD0;
	localparam addr_t OFS_GFX_CTL   = 28'h108040;
	localparam addr_t OFS_PROTECTED = 28'h10100C;
	localparam addr_t OFS_VF_CAP    = 28'h1901F8;
	localparam addr_t OFS_AUX_A     = 28'h64010;
	localparam addr_t OFS_AUX_B     = 28'h64110;
	localparam addr_t OFS_PP_STAT   = 28'h61200;
	localparam addr_t OFS_PP_CTL    = 28'h61204;
	localparam addr_t OFS_WELL1     = 28'h45400;
	localparam addr_t OFS_WELL2     = 28'h45404;
	localparam addr_t OFS_WELL3     = 28'h45408;
	localparam addr_t OFS_WELL4     = 28'h4540C;
	localparam addr_t OFS_PLL       = 28'h46070;
	localparam addr_t OFS_FUSE      = 28'h42000;
	localparam addr_t OFS_SLICE0    = 28'h45008;
	localparam addr_t OFS_SLICE1    = 28'h44FE8;
	localparam addr_t OFS_SLICE2    = 28'h44300;
	localparam addr_t OFS_SLICE3    = 28'h44304;
	localparam addr_t OFS_CDCLK     = 28'h46000;
	localparam addr_t OFS_DC_STATE  = 28'h45504;

	// fixed read words
	localparam word_t VAL_GT_ID     = 32'h0500_4001;
	localparam word_t VAL_DISP_ID   = 32'h0380_4000;
	localparam word_t VAL_PP_STAT   = 32'hC000_0000;
	localparam word_t VAL_WELL      = 32'hFFFF_FFFF;
	localparam word_t VAL_FUSE      = 32'h8FFC_0000;
	localparam word_t VAL_GFX_CTL   = 32'h0000_04C0;
	localparam word_t VAL_MEM_INFO  = 32'h0000_0112;
	localparam word_t VAL_PROTECTED = 32'h0000_0200;
	localparam word_t VAL_CDCLK     = 32'h0800_0000;
	localparam word_t VAL_ZERO      = 32'h0000_0000;

	// bit masks
	localparam word_t BIT31 = 32'h8000_0000;
	localparam word_t BIT30 = 32'h4000_0000;
	localparam word_t BIT28 = 32'h1000_0000;
	localparam word_t BIT25 = 32'h0200_0000;
	localparam word_t BIT18 = 32'h0004_0000;

	localparam word_t DC_READ_SET = 32'h4000_000B;

	// reset values
	localparam word_t RST_POWER_STATE = 32'h2000_0000;
	localparam word_t RST_STEER_LOCK  = 32'h0000_0001;

	localparam int unsigned NumSlices = 4;
	localparam int unsigned SliceIdxW = $clog2(NumSlices);

endpackage

@@ src/gpu_mmio_register_stub.sv @@
`timescale 1ns / 1ps
// Pipeline: an access goes through the input register, then the result
// register, which holds its read word until the sink takes it.
// Throughput: one access per cycle unless the sink stalls with both registers
// full; the register file is read and updated between the two registers.
// Reset: arst_n is asynchronous, active low; clears both stage valids and puts
// every register file word to reset (DC state 0x20000000, steering lock 1).
// ----------------------------------------------------------------------------
// gpu_mmio_register_stub: graphics-controller register block
// Takes one 32-bit read or write per transfer and returns one read word.
// ----------------------------------------------------------------------------
module gpu_mmio_register_stub (
	input  logic                clk,
	input  logic                arst_n,
	// access channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  gms_pkg::addr_t      addr,
	input  gms_pkg::word_t      wdata,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output gms_pkg::word_t      rdata
);
	import gms_pkg::*;

	// input stage
	logic        valid_s1;
	gms_access_t acc_s1;

	// result register
	logic  out_valid_q;
	word_t rdata_q;

	logic  advance;   // stage 1 may move into the result register
	logic  fire;      // access in stage 1 is served this cycle
	word_t rd_comb;

	// Stage 1 moves on whenever the result register is empty or being
	// taken, so back-to-back transfers flow at one per cycle. Stall only
	// backs up when both stages are full and the sink is stalling.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			acc_s1.op    <= op;
			acc_s1.addr  <= addr;
			acc_s1.wdata <= wdata;
		end
	end

	// Register file: state updates happen as the access leaves stage 1,
	// so side effects land in transfer order.
	gms_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.acc    (acc_s1),
		.rdata  (rd_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rdata_q <= rd_comb;
		end
	end

	assign out_valid = out_valid_q;
	assign rdata     = rdata_q;

`ifndef SYNTHESIS
	// input only backs up when both stages hold an item and the sink stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a full pipeline");

	// every served access shows up in the result register next cycle
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("served access produced no result");

	// a write always returns zero read data
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && acc_s1.op == OP_WRITE) |=> (rdata_q == VAL_ZERO))
		else $error("write returned non-zero data");
`endif

endmodule

@@ src/gms_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gms_regs: register file and address decode
// Serves one access per enabled cycle: read mux plus read/write side effects.
// ----------------------------------------------------------------------------
module gms_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  gms_pkg::gms_access_t acc,
	output gms_pkg::word_t      rdata
);
	import gms_pkg::*;

	word_t wake_gsc_q;
	word_t wake_gt_q;
	word_t pll_word_q;
	word_t slice_ctl_q [NumSlices];
	word_t panel_ctl_q;
	word_t power_state_q;
	word_t steer_lock_q;
	word_t aux_ctl_word_q;

	logic                 slice_hit;
	logic [SliceIdxW-1:0] slice_idx;
	word_t                rd;
	word_t                aux_new;

	always_comb begin
		slice_hit = 1'b1;
		slice_idx = '0;
		case (acc.addr)
			OFS_SLICE0: slice_idx = SliceIdxW'(0);
			OFS_SLICE1: slice_idx = SliceIdxW'(1);
			OFS_SLICE2: slice_idx = SliceIdxW'(2);
			OFS_SLICE3: slice_idx = SliceIdxW'(3);
			default:    slice_hit = 1'b0;
		endcase
	end

	// done and bit 18 set, busy/error cleared
	assign aux_new = (acc.wdata & ~(BIT31 | BIT28 | BIT25)) | BIT30 | BIT18;

	always_comb begin
		rd = VAL_ZERO;
		if (slice_hit) begin
			rd = slice_ctl_q[slice_idx] | BIT30;
		end else begin
			case (acc.addr)
				OFS_GT_ID:                 rd = VAL_GT_ID;
				OFS_DISP_ID:               rd = VAL_DISP_ID;
				OFS_ACK_GSC:               rd = wake_gsc_q;
				OFS_ACK_GT_A, OFS_ACK_GT_B: rd = wake_gt_q;
				OFS_PP_STAT:               rd = VAL_PP_STAT;
				OFS_PP_CTL:                rd = panel_ctl_q;
				OFS_WELL1, OFS_WELL2,
				OFS_WELL3, OFS_WELL4:      rd = VAL_WELL;
				OFS_PLL:                   rd = pll_word_q & ~BIT31;
				OFS_FUSE:                  rd = VAL_FUSE;
				OFS_GFX_CTL:               rd = VAL_GFX_CTL;
				OFS_VF_CAP:                rd = VAL_ZERO;
				OFS_MEM_INFO:              rd = VAL_MEM_INFO;
				OFS_PROTECTED:             rd = VAL_PROTECTED;
				OFS_CDCLK:                 rd = VAL_CDCLK;
				OFS_DC_STATE:              rd = power_state_q | DC_READ_SET;
				OFS_AUX_A, OFS_AUX_B:      rd = aux_ctl_word_q;
				OFS_STEER:                 rd = steer_lock_q;
				default:                   rd = VAL_ZERO;
			endcase
		end
	end

	assign rdata = (acc.op == OP_WRITE) ? VAL_ZERO : rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_gsc_q     <= '0;
			wake_gt_q      <= '0;
			pll_word_q     <= '0;
			for (int i = 0; i < NumSlices; i++) begin
				slice_ctl_q[i] <= '0;
			end
			panel_ctl_q    <= '0;
			power_state_q  <= RST_POWER_STATE;
			steer_lock_q   <= RST_STEER_LOCK;
			aux_ctl_word_q <= '0;
		end else if (fire) begin
			if (acc.op == OP_WRITE) begin
				if (slice_hit) begin
					slice_ctl_q[slice_idx] <= acc.wdata;
				end else begin
					case (acc.addr)
						OFS_WAKE_GSC: wake_gsc_q <= acc.wdata;
						OFS_WAKE_GT:  wake_gt_q <= acc.wdata;
						OFS_STEER:    steer_lock_q <= acc.wdata;
						OFS_AUX_A, OFS_AUX_B: begin
							if (acc.wdata[31]) begin
								aux_ctl_word_q <= aux_new;
							end
						end
						OFS_PLL:      pll_word_q <= acc.wdata;
						OFS_PP_CTL:   panel_ctl_q <= acc.wdata;
						OFS_DC_STATE: power_state_q <= power_state_q | acc.wdata;
						default:      ;
					endcase
				end
			end else begin
				// read side effects
				case (acc.addr)
					OFS_PLL:      pll_word_q <= pll_word_q & ~BIT31;
					OFS_DC_STATE: power_state_q <= power_state_q | DC_READ_SET;
					default:      ;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// DC state bit 29 is set at reset and can only be ORed, never cleared
	a_dc_bit29_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		power_state_q[29])
		else $error("DC state bit 29 lost");

	// a read of the PLL word never returns bit 31
	a_pll_read_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc.op == OP_READ && acc.addr == OFS_PLL) |-> !rdata[31])
		else $error("PLL read returned bit 31");

	// an AUX write without bit 31 leaves the control word alone
	a_aux_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && acc.op == OP_WRITE && !acc.wdata[31]) |=> $stable(aux_ctl_word_q))
		else $error("AUX control changed without bit 31");
`endif

endmodule

@@ dv/gpu_mmio_register_stub_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_mmio_register_stub_tb: self-checking bench for the register stub
// Drives read and write transfers, tracks the register file alongside the
// block and checks every returned read word in order, under random gaps,
// output stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module gpu_mmio_register_stub_tb;
	import gms_pkg::*;

	localparam int unsigned NUM_MAPPED   = 28;      // offsets listed in mapped_offset()
	localparam int unsigned HOLD_CYCLES  = 300;     // long output hold-off
	localparam int unsigned SETTLE_CYCLES = 8;      // allow slack after the last result
	localparam int unsigned CYCLE_LIMIT  = 200000;  // well above the slowest correct run

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN,
		STALL_HEAVY
	} stall_mode_t;

	// one outstanding read word, with the access that produced it
	typedef struct packed {
		logic  op;
		addr_t addr;
		word_t rdata;
	} pending_word_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_stall;
	logic  op        = OP_READ;
	addr_t addr      = '0;
	word_t wdata     = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	word_t rdata;

	gpu_mmio_register_stub dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.addr      (addr),
		.wdata     (wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rdata     (rdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Register file as the block should hold it
	// ------------------------------------------------------------------------
	word_t fw_gsc;
	word_t fw_gt;
	word_t pll_en;
	word_t slice_word [NumSlices];
	word_t pp_ctl;
	word_t dcs_word;
	word_t steer_sem;
	word_t aux_ctl;

	pending_word_t read_words_due[$];

	int unsigned error_count = 0;
	int unsigned n_reads     = 0;
	int unsigned n_writes    = 0;
	int unsigned n_checked   = 0;
	int unsigned in_held     = 0;
	int unsigned out_held    = 0;
	int unsigned cycle_count = 0;

	// sender pacing
	bit          pace_on    = 1'b1;
	bit          offering   = 1'b0;   // shadow of in_valid as last driven
	int unsigned burst_left = 0;

	// receiver control: mode and hold-off requests are set from the test tasks
	stall_mode_t stall_mode  = STALL_NONE;
	int unsigned hold_asked  = 0;
	int unsigned hold_taken  = 0;
	int unsigned hold_left   = 0;
	int unsigned rx_tick     = 0;

	function automatic void clear_register_file();
		fw_gsc    = '0;
		fw_gt     = '0;
		pll_en    = '0;
		for (int i = 0; i < NumSlices; i++) slice_word[i] = '0;
		pp_ctl    = '0;
		dcs_word  = RST_POWER_STATE;
		steer_sem = RST_STEER_LOCK;
		aux_ctl   = '0;
	endfunction

	// Applies one access to the register file and returns the word the
	// block should hand back for it (zero for every write).
	function automatic word_t predict_rdata(logic is_write, addr_t a, word_t w);
		word_t r;
		r = VAL_ZERO;
		if (is_write == OP_WRITE) begin
			case (a)
				OFS_SLICE0:   slice_word[0] = w;
				OFS_SLICE1:   slice_word[1] = w;
				OFS_SLICE2:   slice_word[2] = w;
				OFS_SLICE3:   slice_word[3] = w;
				OFS_WAKE_GSC: fw_gsc = w;
				OFS_WAKE_GT:  fw_gt = w;
				OFS_STEER:    steer_sem = w;
				OFS_PLL:      pll_en = w;
				OFS_PP_CTL:   pp_ctl = w;
				OFS_DC_STATE: dcs_word = dcs_word | w;
				// AUX: only a write that starts a transaction lands, and it
				// completes at once - busy/error cleared, done and bit 18 set
				OFS_AUX_A, OFS_AUX_B: begin
					if ((w & BIT31) != '0)
						aux_ctl = (w & ~(BIT31 | BIT28 | BIT25)) | BIT30 | BIT18;
				end
				default: ;
			endcase
		end else begin
			case (a)
				OFS_SLICE0:   r = slice_word[0] | BIT30;
				OFS_SLICE1:   r = slice_word[1] | BIT30;
				OFS_SLICE2:   r = slice_word[2] | BIT30;
				OFS_SLICE3:   r = slice_word[3] | BIT30;
				OFS_GT_ID:    r = VAL_GT_ID;
				OFS_DISP_ID:  r = VAL_DISP_ID;
				OFS_ACK_GSC:  r = fw_gsc;
				OFS_ACK_GT_A, OFS_ACK_GT_B: r = fw_gt;
				OFS_PP_STAT:  r = VAL_PP_STAT;
				OFS_PP_CTL:   r = pp_ctl;
				OFS_WELL1, OFS_WELL2, OFS_WELL3, OFS_WELL4: r = VAL_WELL;
				// PLL lock: reading clears the enable request bit until the next write
				OFS_PLL: begin
					pll_en = pll_en & ~BIT31;
					r = pll_en;
				end
				OFS_FUSE:      r = VAL_FUSE;
				OFS_GFX_CTL:   r = VAL_GFX_CTL;
				OFS_VF_CAP:    r = VAL_ZERO;
				OFS_MEM_INFO:  r = VAL_MEM_INFO;
				OFS_PROTECTED: r = VAL_PROTECTED;
				OFS_CDCLK:     r = VAL_CDCLK;
				// DC state picks up its status bits on every read, sticky
				OFS_DC_STATE: begin
					dcs_word = dcs_word | DC_READ_SET;
					r = dcs_word;
				end
				OFS_AUX_A, OFS_AUX_B: r = aux_ctl;
				OFS_STEER:     r = steer_sem;
				default:       r = VAL_ZERO;
			endcase
		end
		return r;
	endfunction

	// Every offset the block decodes, write-only request words included.
	function automatic addr_t mapped_offset(int unsigned idx);
		case (idx)
			0:  return OFS_GT_ID;
			1:  return OFS_DISP_ID;
			2:  return OFS_WAKE_GSC;
			3:  return OFS_ACK_GSC;
			4:  return OFS_WAKE_GT;
			5:  return OFS_ACK_GT_A;
			6:  return OFS_ACK_GT_B;
			7:  return OFS_MEM_INFO;
			8:  return OFS_STEER;
			9:  return OFS_GFX_CTL;
			10: return OFS_PROTECTED;
			11: return OFS_VF_CAP;
			12: return OFS_AUX_A;
			13: return OFS_AUX_B;
			14: return OFS_PP_STAT;
			15: return OFS_PP_CTL;
			16: return OFS_WELL1;
			17: return OFS_WELL2;
			18: return OFS_WELL3;
			19: return OFS_WELL4;
			20: return OFS_PLL;
			21: return OFS_FUSE;
			22: return OFS_SLICE0;
			23: return OFS_SLICE1;
			24: return OFS_SLICE2;
			25: return OFS_SLICE3;
			26: return OFS_CDCLK;
			default: return OFS_DC_STATE;
		endcase
	endfunction

	task automatic report_mismatch(string what, addr_t a, word_t want, word_t got);
		$display("[%0t] MISMATCH %s: addr 0x%07h expected 0x%08h got 0x%08h",
			$time, what, a, want, got);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// After a transfer: keep offering inside a burst, else drop valid for a
	// random gap and pick the next burst length.
	task automatic pace_sender();
		int unsigned gap;
		if (!pace_on) return;
		if (burst_left != 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 12);
		gap = $urandom_range(1, 6);
		in_valid <= 1'b0;
		offering = 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Offers one access and returns at the edge where it transfers. Called
	// at a rising edge; valid stays up if the next access follows at once.
	task automatic send_access(logic acc_op, addr_t acc_addr, word_t acc_wdata);
		pending_word_t due;
		in_valid <= 1'b1;
		op       <= acc_op;
		addr     <= acc_addr;
		wdata    <= acc_wdata;
		offering = 1'b1;
		do @(posedge clk); while (in_stall);
		due.op    = acc_op;
		due.addr  = acc_addr;
		due.rdata = predict_rdata(acc_op, acc_addr, acc_wdata);
		read_words_due.push_back(due);
		if (acc_op == OP_WRITE) n_writes++;
		else n_reads++;
		pace_sender();
	endtask

	// write data on a read transfer is junk the block must ignore
	task automatic rd(addr_t a);
		send_access(OP_READ, a, $urandom);
	endtask

	task automatic wr(addr_t a, word_t w);
		send_access(OP_WRITE, a, w);
	endtask

	task automatic wait_all_results();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (read_words_due.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: own stall pattern, plus a counted hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_left  <= 0;
			hold_taken <= 0;
			rx_tick    <= 0;
		end else begin
			rx_tick <= rx_tick + 1;
			if (hold_asked != hold_taken) begin
				hold_taken <= hold_asked;
				hold_left  <= HOLD_CYCLES;
				out_stall  <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 30);
					STALL_PATTERN: out_stall <= ((rx_tick % 11) < 4);
					STALL_HEAVY:   out_stall <= ($urandom_range(0, 99) < 70);
					default:       out_stall <= 1'b0;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker and watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		pending_word_t due;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles, %0d read words still due",
				$time, cycle_count, read_words_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && in_stall) in_held++;
			if (out_valid && out_stall) out_held++;
			if (out_valid && !out_stall) begin
				if (read_words_due.size() == 0) begin
					report_mismatch("result with no access outstanding", '0, '0, rdata);
				end else begin
					due = read_words_due.pop_front();
					n_checked++;
					if (rdata !== due.rdata)
						report_mismatch(due.op == OP_WRITE ? "rdata after write"
							: "rdata after read", due.addr, due.rdata, rdata);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Values straight out of reset, DC state picking up its read bits.
	task automatic test_power_up_values();
		rd(OFS_DC_STATE);
		rd(OFS_STEER);
		rd(OFS_GT_ID);
		rd(OFS_VF_CAP);
		rd(OFS_WELL1);
	endtask

	// DC state ORs in written bits and never loses them.
	task automatic test_dc_state_or();
		wr(OFS_DC_STATE, 32'h00F0_0000);
		rd(OFS_DC_STATE);
	endtask

	// Read of the PLL enable word drops bit 31, and the drop sticks.
	task automatic test_pll_clear_on_read();
		wr(OFS_PLL, 32'hFFFF_FFFF);
		rd(OFS_PLL);
		rd(OFS_PLL);
	endtask

	// Slice controls always read back with bit 30 set.
	task automatic test_slice_bit30();
		wr(OFS_SLICE3, 32'h0000_0000);
		rd(OFS_SLICE3);
		wr(OFS_SLICE0, 32'hFFFF_FFFF);
		rd(OFS_SLICE0);
	endtask

	// AUX: a write with bit 31 completes instantly, without it is dropped.
	// Both aliases share the one control word.
	task automatic test_aux_completion();
		wr(OFS_AUX_A, 32'hFFFF_FFFF);
		rd(OFS_AUX_B);
		wr(OFS_AUX_B, 32'h7FFF_FFFF);
		rd(OFS_AUX_A);
	endtask

	// Writes to a fixed word are dropped; forcewake requests read as zero
	// and show up on the acknowledge offset instead.
	task automatic test_read_only_and_write_only();
		wr(OFS_FUSE, 32'h0000_0000);
		rd(OFS_FUSE);
		wr(OFS_WAKE_GT, 32'h1234_5678);
		rd(OFS_WAKE_GT);
		rd(OFS_ACK_GT_A);
	endtask

	// Unmapped offsets at both ends of the window.
	task automatic test_unmapped();
		wr(28'hFFF_FFFF, 32'hFFFF_FFFF);
		rd(28'hFFF_FFFF);
		rd(28'h000_0000);
	endtask

	// Output held off for a long stretch while the sender keeps offering
	// back to back, so the pipe fills and the input stalls.
	task automatic test_output_hold_off();
		pace_on = 1'b0;
		stall_mode <= STALL_NONE;
		hold_asked <= hold_asked + 1;
		for (int i = 0; i < 40; i++)
			send_access(OP_READ, mapped_offset($urandom_range(0, NUM_MAPPED - 1)), $urandom);
		wait_all_results();
		pace_on = 1'b1;
	endtask

	// Random traffic, mostly on decoded offsets so reads follow writes,
	// with near misses and raw offsets mixed in. Phases vary the idling.
	task automatic test_random_traffic(int unsigned n_items);
		int unsigned sel;
		int unsigned phase;
		addr_t       a;
		word_t       w;
		logic        o;
		phase = 0;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 75 == 0) begin
				// phase 1 runs flat out with neither side idling
				pace_on = (phase != 1);
				case (phase % 4)
					0:       stall_mode <= STALL_RANDOM;
					1:       stall_mode <= STALL_NONE;
					2:       stall_mode <= STALL_PATTERN;
					default: stall_mode <= STALL_HEAVY;
				endcase
				phase++;
			end
			sel = $urandom_range(0, 99);
			if (sel < 65)
				a = mapped_offset($urandom_range(0, NUM_MAPPED - 1));
			else if (sel < 80)
				a = mapped_offset($urandom_range(0, NUM_MAPPED - 1))
					^ (addr_t'(1) << $urandom_range(0, AddrW - 1));
			else
				a = addr_t'($urandom);
			sel = $urandom_range(0, 99);
			if (sel < 10)      w = 32'h0000_0000;
			else if (sel < 20) w = 32'hFFFF_FFFF;
			else               w = $urandom;
			o = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			send_access(o, a, w);
		end
		pace_on = 1'b1;
	endtask

	// Sender pauses until every read word is back, then resumes.
	task automatic test_pause_until_drained();
		stall_mode <= STALL_RANDOM;
		for (int i = 0; i < 20; i++)
			send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
				mapped_offset($urandom_range(0, NUM_MAPPED - 1)), $urandom);
		wait_all_results();
		for (int i = 0; i < 20; i++)
			send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ,
				mapped_offset($urandom_range(0, NUM_MAPPED - 1)), $urandom);
	endtask

	initial begin
		clear_register_file();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		stall_mode <= STALL_RANDOM;

		test_power_up_values();
		test_dc_state_or();
		test_pll_clear_on_read();
		test_slice_bit30();
		test_aux_completion();
		test_read_only_and_write_only();
		test_unmapped();
		test_output_hold_off();
		test_random_traffic(340);
		test_pause_until_drained();

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d reads and %0d writes, %0d read words checked.",
			n_reads, n_writes, n_checked);
		$display("Input held back %0d cycles, output held back %0d cycles.",
			in_held, out_held);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
